// ----- src/trmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmv_pkg: shared types and constants of the texel running mean core
// Record layout of one texel and widths of the serial divider.
// ----------------------------------------------------------------------------
package trmv_pkg;

    localparam int COLOR_W  = 24;
    localparam int SPREAD_W = 48;
    localparam int TIME_W   = 32;
    localparam int OBJ_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int NUM_CH   = 3;

    // Dividend of the shared divider: magnitude plus half the divisor.
    localparam int DIV_W    = 33;
    localparam int STEP_W   = 6;

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 16'hFFFF;
    localparam logic [SPREAD_W-1:0] SPREAD_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [COUNT_W-1:0]                 count;
        logic [OBJ_W-1:0]                   obj;
        logic [TIME_W-1:0]                  time_ns;
        logic [NUM_CH-1:0][SPREAD_W-1:0]    spread;
        logic [NUM_CH-1:0][COLOR_W-1:0]     mean;
    } t_rec;

endpackage

// ----- src/trmv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmv_if: request channels of the texel running mean core
// Sample channel in and result channel out, valid/ready with payload.
// ----------------------------------------------------------------------------
interface trmv_sample_if;
    logic        valid;
    logic        ready;
    logic [7:0]  texel_x;
    logic [7:0]  texel_y;
    logic [23:0] sample_red;
    logic [23:0] sample_green;
    logic [23:0] sample_blue;
    logic [31:0] sample_time;
    logic [15:0] hit_object;

    modport source (output valid, texel_x, texel_y, sample_red, sample_green,
                    sample_blue, sample_time, hit_object, input ready);
    modport sink (input valid, texel_x, texel_y, sample_red, sample_green,
                  sample_blue, sample_time, hit_object, output ready);
endinterface

interface trmv_result_if;
    logic        valid;
    logic        ready;
    logic [23:0] mean_red;
    logic [23:0] mean_green;
    logic [23:0] mean_blue;
    logic [47:0] spread_red;
    logic [47:0] spread_green;
    logic [47:0] spread_blue;
    logic [15:0] sample_count;
    logic [31:0] mean_time;
    logic [15:0] first_object_id;

    modport source (output valid, mean_red, mean_green, mean_blue, spread_red,
                    spread_green, spread_blue, sample_count, mean_time,
                    first_object_id, input ready);
    modport sink (input valid, mean_red, mean_green, mean_blue, spread_red,
                  spread_green, spread_blue, sample_count, mean_time,
                  first_object_id, output ready);
endinterface

// ----- src/texel_running_mean_variance_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_running_mean_variance_core: per-texel Welford mean and variance
// Keeps one record per texel and returns the updated record per sample.
// ----------------------------------------------------------------------------
// Usage:
// i_sample carries one ray sample per request; o_result returns one updated
// texel record per sample, in order. A sample outside the grid changes nothing
// and returns an all-zero record.
// A texel's first sample passes S_READ, S_WAIT, S_WRITE and S_OUT; a sample
// outside the grid goes straight to S_OUT. A repeat sample runs the single
// shared restoring divider for 33 steps for each of the three colors and the
// time, and a single multiplier forms each channel's spread term. The next
// request can be taken in the cycle after the result is loaded.
// i_sample.ready is high only while the core is idle; one sample is in flight.
// After reset the core sweeps the record memory to clear every sample count,
// one entry per cycle, before taking requests.
// When the receiver stalls, the finished result waits in the output register
// and the core still takes and works the next sample; it then waits to hand
// over that second result until the first one is taken.
// ----------------------------------------------------------------------------
module texel_running_mean_variance_core
    import trmv_pkg::*;
#(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    trmv_sample_if.sink   i_sample,
    trmv_result_if.source o_result
);

    localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_WAIT, S_SETUP, S_DIV,
        S_UPD, S_MUL, S_ACC, S_WRITE, S_OUT
    } t_state;

    t_rec mem [DEPTH];
    t_rec r_rd;

    t_state                 r_state;
    logic [ADDR_W-1:0]      r_addr;
    t_rec                   r_rec;
    logic [COUNT_W-1:0]     r_n;
    logic [1:0]             r_ch;
    logic [STEP_W-1:0]      r_step;
    logic [DIV_W-1:0]       r_dvd;
    logic [COUNT_W-1:0]     r_rem;
    logic                   r_neg;
    logic [COLOR_W-1:0]     r_mag;
    logic [COLOR_W-1:0]     r_m2;
    logic [SPREAD_W-1:0]    r_prod;

    logic [NUM_CH-1:0][COLOR_W-1:0] r_smp;
    logic [TIME_W-1:0]      r_time;
    logic [OBJ_W-1:0]       r_obj;

    logic                   r_ov;
    t_rec                   r_out;

    // Combinational helpers
    logic                   in_range;
    logic [ADDR_W-1:0]      n_idx;
    logic [COUNT_W-1:0]     n_cnt;
    t_rec                   rd_upd;
    logic [TIME_W-1:0]      cur_new;
    logic [TIME_W-1:0]      cur_old;
    logic [33:0]            diff;
    logic [DIV_W-1:0]       mag;
    logic [COUNT_W:0]       rem_sh;
    logic                   fits;
    logic [34:0]            upd;
    logic [TIME_W-1:0]      upd_clamp;
    logic [25:0]            d2;
    logic [SPREAD_W:0]      acc;
    logic                   mem_we;
    logic                   out_load;

    assign in_range = ({24'd0, i_sample.texel_x} < 32'(GRID_WIDTH)) &&
                      ({24'd0, i_sample.texel_y} < 32'(GRID_HEIGHT));
    assign n_idx = ADDR_W'(32'(i_sample.texel_x) +
                           32'(i_sample.texel_y) * 32'(GRID_WIDTH));
    assign n_cnt = (r_rd.count == COUNT_MAX) ? COUNT_MAX : r_rd.count + 1'b1;

    always_comb begin
        rd_upd       = r_rd;
        rd_upd.count = n_cnt;
    end

    always_comb begin
        if (r_ch == 2'd3) begin
            cur_new = r_time;
            cur_old = r_rec.time_ns;
        end else begin
            cur_new = {8'd0, r_smp[r_ch]};
            cur_old = {8'd0, r_rec.mean[r_ch]};
        end
    end

    assign diff   = {2'b00, cur_new} - {2'b00, cur_old};
    assign mag    = diff[33] ? DIV_W'(-diff) : diff[DIV_W-1:0];
    assign rem_sh = {r_rem, r_dvd[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, r_n};

    // Quotient is in r_dvd once all steps have run.
    always_comb begin
        upd = r_neg ? ({3'b000, cur_old} - {2'b00, r_dvd})
                    : ({3'b000, cur_old} + {2'b00, r_dvd});
        if (upd[34]) begin
            upd_clamp = '0;
        end else if (r_ch == 2'd3) begin
            upd_clamp = (upd[33:32] != 2'b00) ? '1 : upd[31:0];
        end else begin
            upd_clamp = (upd[33:24] != 10'd0) ? 32'h00FF_FFFF : upd[31:0];
        end
    end

    assign d2  = {2'b00, r_smp[r_ch[1:0] == 2'd3 ? 2'd0 : r_ch]} -
                 {2'b00, upd_clamp[COLOR_W-1:0]};
    assign acc = {1'b0, r_rec.spread[r_ch[1:0] == 2'd3 ? 2'd0 : r_ch]} +
                 {1'b0, r_prod};

    assign mem_we   = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign out_load = (r_state == S_OUT) && (!r_ov || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= (r_state == S_CLEAR) ? '0 : r_rec;
        end
        r_rd <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_result.valid && o_result.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_sample.valid) begin
                        r_smp[0] <= i_sample.sample_red;
                        r_smp[1] <= i_sample.sample_green;
                        r_smp[2] <= i_sample.sample_blue;
                        r_time   <= i_sample.sample_time;
                        r_obj    <= i_sample.hit_object;
                        if (in_range) begin
                            r_addr  <= n_idx;
                            r_state <= S_READ;
                        end else begin
                            r_rec   <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_rd.count == '0) begin
                        r_rec.mean[0] <= r_smp[0];
                        r_rec.mean[1] <= r_smp[1];
                        r_rec.mean[2] <= r_smp[2];
                        r_rec.spread  <= '0;
                        r_rec.time_ns <= r_time;
                        r_rec.obj     <= r_obj;
                        r_rec.count   <= COUNT_W'(1);
                        r_state       <= S_WRITE;
                    end else begin
                        r_rec       <= rd_upd;
                        r_n         <= n_cnt;
                        r_ch        <= 2'd0;
                        r_state     <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_neg   <= diff[33];
                    r_mag   <= mag[COLOR_W-1:0];
                    r_dvd   <= mag + {{(DIV_W-COUNT_W+1){1'b0}}, r_n[COUNT_W-1:1]};
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= fits ? COUNT_W'(rem_sh - {1'b0, r_n})
                                   : rem_sh[COUNT_W-1:0];
                    r_dvd  <= {r_dvd[DIV_W-2:0], fits};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_W - 1)) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_ch == 2'd3) begin
                        r_rec.time_ns <= upd_clamp;
                        r_state       <= S_WRITE;
                    end else begin
                        r_rec.mean[r_ch] <= upd_clamp[COLOR_W-1:0];
                        // Second deviation, clipped to the side of the first.
                        if (r_neg) begin
                            r_m2 <= d2[25] ? COLOR_W'(-d2) : '0;
                        end else begin
                            r_m2 <= (!d2[25] && d2 != '0) ? d2[COLOR_W-1:0] : '0;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_mag * r_m2;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_rec.spread[r_ch] <= acc[SPREAD_W] ? SPREAD_MAX
                                                        : acc[SPREAD_W-1:0];
                    r_ch    <= r_ch + 1'b1;
                    r_state <= S_SETUP;
                end
                S_WRITE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out   <= r_rec;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_sample.ready = (r_state == S_IDLE);

    assign o_result.valid           = r_ov;
    assign o_result.mean_red        = r_out.mean[0];
    assign o_result.mean_green      = r_out.mean[1];
    assign o_result.mean_blue       = r_out.mean[2];
    assign o_result.spread_red      = r_out.spread[0];
    assign o_result.spread_green    = r_out.spread[1];
    assign o_result.spread_blue     = r_out.spread[2];
    assign o_result.sample_count    = r_out.count;
    assign o_result.mean_time       = r_out.time_ns;
    assign o_result.first_object_id = r_out.obj;

endmodule

// ----- src/trmv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmv_checker: port-level checks of the texel running mean core
// Watches the request channels and the shape of returned records.
// ----------------------------------------------------------------------------
module trmv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [47:0] i_spread_red,
    input logic [47:0] i_spread_green,
    input logic [47:0] i_spread_blue,
    input logic [15:0] i_sample_count,
    input logic [31:0] i_mean_time,
    input logic [15:0] i_first_object_id
);

    // Result request stays up until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_sample_count) &&
        $stable(i_mean_time) && $stable(i_spread_red))
        else $error("result payload changed while stalled");

    // Only one sample is in flight at a time.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while another is in work");

    // A zero-count (dropped) result has zero time, object id and red spread.
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sample_count == 16'd0 |-> i_mean_time == 32'd0 &&
        i_first_object_id == 16'd0 && i_spread_red == 48'd0)
        else $error("dropped sample returned nonzero record");

    // A texel's first sample has no spread.
    a_first_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sample_count == 16'd1 |-> i_spread_red == 48'd0 &&
        i_spread_green == 48'd0 && i_spread_blue == 48'd0)
        else $error("first sample returned nonzero spread");

endmodule

bind texel_running_mean_variance_core trmv_checker u_trmv_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_sample.valid),
    .i_in_ready        (i_sample.ready),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_spread_red      (o_result.spread_red),
    .i_spread_green    (o_result.spread_green),
    .i_spread_blue     (o_result.spread_blue),
    .i_sample_count    (o_result.sample_count),
    .i_mean_time       (o_result.mean_time),
    .i_first_object_id (o_result.first_object_id)
);

// ----- tb/sv/tb_texel_running_mean_variance_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_texel_running_mean_variance_core: self-checking bench of the texel core
// Drives ray samples through a directed table and a random phase, predicts
// each updated texel record with a Welford model and checks every result.
// ----------------------------------------------------------------------------
module tb_texel_running_mean_variance_core;
    import trmv_pkg::*;

    localparam int GW = 256;
    localparam int GH = 256;
    localparam int NUM_RANDOM = 2000;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [7:0]  tx;
        logic [7:0]  ty;
        logic [23:0] col [3];
        logic [31:0] t;
        logic [15:0] obj;
    } t_sample;

    typedef struct {
        logic [23:0] mean [3];
        logic [47:0] spread [3];
        logic [15:0] count;
        logic [31:0] time_ns;
        logic [15:0] obj;
    } t_record;

    typedef struct {
        t_sample s;
        bit      has_fixed;
        t_record fixed;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    trmv_sample_if smp ();
    trmv_result_if res ();

    texel_running_mean_variance_core #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sample(smp.sink), .o_result(res.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Texel store of the predictor, sparse by texel index.
    logic [23:0] texel_mean [int][3];
    logic [63:0] texel_spread [int][3];
    logic [31:0] texel_time [int];
    logic [15:0] texel_obj [int];
    logic [15:0] texel_cnt [int];

    t_record expected_records [$];
    int      errors = 0;
    longint  cycles = 0;
    bit      stim_done = 0;
    t_row    rows [$];

    function automatic longint rnd_div(longint diff, longint n);
        longint mag;
        longint q;
        mag = (diff < 0) ? -diff : diff;
        q = (mag + n / 2) / n;
        return (diff < 0) ? -q : q;
    endfunction

    function automatic t_record welford_update(t_sample s);
        t_record r;
        int idx;
        longint n, m, d, nm, d2, pr, sp;
        for (int k = 0; k < 3; k++) begin
            r.mean[k] = '0;
            r.spread[k] = '0;
        end
        r.count = '0;
        r.time_ns = '0;
        r.obj = '0;
        if (s.tx >= GW || s.ty >= GH) return r;
        idx = s.tx + s.ty * GW;
        if (!texel_cnt.exists(idx) || texel_cnt[idx] == 0) begin
            for (int k = 0; k < 3; k++) begin
                texel_mean[idx][k] = s.col[k];
                texel_spread[idx][k] = '0;
            end
            texel_time[idx] = s.t;
            texel_obj[idx] = s.obj;
            texel_cnt[idx] = 16'd1;
        end else begin
            n = (texel_cnt[idx] + 1 > 65535) ? 65535 : texel_cnt[idx] + 1;
            for (int k = 0; k < 3; k++) begin
                m = texel_mean[idx][k];
                d = longint'(s.col[k]) - m;
                nm = m + rnd_div(d, n);
                if (nm < 0) nm = 0;
                if (nm > 64'hFFFFFF) nm = 64'hFFFFFF;
                d2 = longint'(s.col[k]) - nm;
                if (d < 0) pr = (d2 < 0) ? (-d) * (-d2) : 0;
                else pr = (d2 > 0) ? d * d2 : 0;
                sp = texel_spread[idx][k];
                if (sp > SPREAD_MAX) sp = SPREAD_MAX;
                sp = (pr > longint'(SPREAD_MAX) - sp) ? longint'(SPREAD_MAX) : sp + pr;
                texel_mean[idx][k] = nm[23:0];
                texel_spread[idx][k] = sp;
            end
            texel_time[idx] = 32'(longint'(texel_time[idx])
                + rnd_div(longint'(s.t) - longint'(texel_time[idx]), n));
            texel_cnt[idx] = n[15:0];
        end
        for (int k = 0; k < 3; k++) begin
            r.mean[k] = texel_mean[idx][k];
            r.spread[k] = texel_spread[idx][k][47:0];
        end
        r.count = texel_cnt[idx];
        r.time_ns = texel_time[idx];
        r.obj = texel_obj[idx];
        return r;
    endfunction

    function automatic t_sample mk(int tx, int ty, int r, int g, int b,
                                   longint t, int obj);
        t_sample s;
        s.tx = 8'(tx);
        s.ty = 8'(ty);
        s.col[0] = 24'(r);
        s.col[1] = 24'(g);
        s.col[2] = 24'(b);
        s.t = 32'(t);
        s.obj = 16'(obj);
        return s;
    endfunction

    function automatic t_sample rand_sample(int hot_x, int hot_y);
        t_sample s;
        int mode;
        mode = $urandom_range(0, 9);
        // Most requests hit a few hot texels so the running means get deep.
        s.tx = 8'((mode < 7) ? hot_x + int'($urandom_range(0, 3))
                             : int'($urandom_range(0, 255)));
        s.ty = 8'((mode < 7) ? hot_y + int'($urandom_range(0, 1))
                             : int'($urandom_range(0, 255)));
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
                0: s.col[k] = '0;
                1: s.col[k] = 24'hFFFFFF;
                default: s.col[k] = 24'($urandom);
            endcase
        end
        s.t = ($urandom_range(0, 5) == 0) ? 32'hFFFFFFFF : $urandom;
        s.obj = 16'($urandom);
        return s;
    endfunction

    // The request stays up after acceptance so that a sample with no gap
    // follows at once; it is dropped only when a gap is drawn.
    task automatic send_sample(t_sample s);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.texel_x <= s.tx;
        smp.texel_y <= s.ty;
        smp.sample_red <= s.col[0];
        smp.sample_green <= s.col[1];
        smp.sample_blue <= s.col[2];
        smp.sample_time <= s.t;
        smp.hit_object <= s.obj;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        expected_records.insert(expected_records.size(), welford_update(s));
    endtask

    task automatic cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result side: random stall per result, check against oldest expectation.
    initial begin
        int stall;
        t_record e;
        res.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, 8);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            @(posedge i_clk);
            while (!res.valid) @(posedge i_clk);
            if (expected_records.size() == 0) begin
                $error("result with no pending sample");
                errors++;
            end else begin
                e = expected_records.pop_front();
                cmp("mean_red", 64'(e.mean[0]), 64'(res.mean_red));
                cmp("mean_green", 64'(e.mean[1]), 64'(res.mean_green));
                cmp("mean_blue", 64'(e.mean[2]), 64'(res.mean_blue));
                cmp("spread_red", 64'(e.spread[0]), 64'(res.spread_red));
                cmp("spread_green", 64'(e.spread[1]), 64'(res.spread_green));
                cmp("spread_blue", 64'(e.spread[2]), 64'(res.spread_blue));
                cmp("sample_count", 64'(e.count), 64'(res.sample_count));
                cmp("mean_time", 64'(e.time_ns), 64'(res.mean_time));
                cmp("first_object_id", 64'(e.obj), 64'(res.first_object_id));
            end
        end
    end

    // Watchdog; the limit covers the post-reset clearing sweep.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_row row;
        t_record got;
        int hx, hy;
        smp.valid = 1'b0;
        smp.texel_x = '0;
        smp.texel_y = '0;
        smp.sample_red = '0;
        smp.sample_green = '0;
        smp.sample_blue = '0;
        smp.sample_time = '0;
        smp.hit_object = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First sample of a texel: record equals the sample.
        row.has_fixed = 1;
        row.s = mk(0, 0, 24'hFFFFFF, 0, 24'h123456, 32'hFFFFFFFF, 16'hFFFF);
        row.fixed.mean = '{24'hFFFFFF, 24'h0, 24'h123456};
        row.fixed.spread = '{48'h0, 48'h0, 48'h0};
        row.fixed.count = 16'd1;
        row.fixed.time_ns = 32'hFFFFFFFF;
        row.fixed.obj = 16'hFFFF;
        rows.insert(rows.size(), row);
        row.s = mk(255, 255, 0, 24'hFFFFFF, 0, 0, 0);
        row.fixed.mean = '{24'h0, 24'hFFFFFF, 24'h0};
        row.fixed.time_ns = '0;
        row.fixed.obj = '0;
        rows.insert(rows.size(), row);
        // Wide swings at (0,0) and (255,255); a close pair at (17,200).
        row.has_fixed = 0;
        row.s = mk(0, 0, 0, 24'hFFFFFF, 24'h123456, 0, 7);
        rows.insert(rows.size(), row);
        row.s = mk(0, 0, 24'hFFFFFF, 0, 0, 32'hFFFFFFFF, 9);
        rows.insert(rows.size(), row);
        row.s = mk(255, 255, 24'hFFFFFF, 0, 24'hFFFFFF, 32'hFFFFFFFF, 1);
        rows.insert(rows.size(), row);
        row.s = mk(255, 255, 24'hAAAAAA, 24'h555555, 3, 32'h5555_5555, 2);
        rows.insert(rows.size(), row);
        row.s = mk(17, 200, 24'h010000, 24'h800000, 24'h7FFFFF, 32'h8000_0000, 16'h8000);
        rows.insert(rows.size(), row);
        row.s = mk(17, 200, 24'h010001, 24'h800000, 24'h7FFFFE, 32'h8000_0001, 16'h0001);
        rows.insert(rows.size(), row);
        foreach (rows[i]) begin
            send_sample(rows[i].s);
            if (rows[i].has_fixed) begin
                got = expected_records[$];
                if (got.count != rows[i].fixed.count || got.mean != rows[i].fixed.mean
                    || got.spread != rows[i].fixed.spread
                    || got.time_ns != rows[i].fixed.time_ns
                    || got.obj != rows[i].fixed.obj) begin
                    $error("table row %0d disagrees with predictor", i);
                    errors++;
                end
            end
        end

        hx = $urandom_range(0, 252);
        hy = $urandom_range(0, 254);
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 500 == 499) begin
                hx = $urandom_range(0, 252);
                hy = $urandom_range(0, 254);
            end
            send_sample(rand_sample(hx, hy));
        end
        smp.valid <= 1'b0;

        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
